### rtl/mci_pkg.sv
// Shared types, constants and saturation helpers for the crossbridge integrator.
`default_nettype none

package mci_pkg;

    // Quotient bits produced by each pipelined divider, one bit per stage.
    localparam int QBITS    = 32;
    // Divider numerator width and width of its high part (the divisor width).
    localparam int NUM_W    = 63;
    localparam int HI_W     = NUM_W - QBITS;
    // Divider depth: one compare stage plus one stage per quotient bit.
    localparam int DIV_LAT  = QBITS + 1;
    // Rate unit depth: product stage, divider, select, product, shift, subtract.
    localparam int RATE_LAT = DIV_LAT + 5;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DETACH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_DETACH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REACH      = 3'd5;

    // Saturation limits.
    localparam logic signed [31:0] MAX32   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32   = 32'sh8000_0000;
    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    // Configuration as seen by the datapath, divisors already forced nonzero.
    typedef struct packed {
        logic [30:0]        time_step;
        logic [30:0]        dt_div;
        logic signed [31:0] velocity;
        logic [30:0]        attach;
        logic [30:0]        detach;
        logic [30:0]        neg_detach;
        logic [30:0]        reach;
        logic [30:0]        reach_div;
    } cfg_t;

    // Integration state of one crossbridge as it moves down the pipeline.
    typedef struct packed {
        logic               vld;
        logic signed [31:0] x;
        logic signed [31:0] n;
        logic signed [31:0] f0;
        logic signed [31:0] nc;
        logic signed [31:0] vc;
        logic signed [31:0] fc;
        logic signed [31:0] xc;
        logic signed [31:0] dv;
        logic signed [31:0] df;
    } st_t;

    // Clamp a wide signed value to 32 bits signed.
    function automatic logic signed [31:0] sat64(input logic signed [63:0] a);
        logic signed [31:0] r;
        if (a > SAT_MAX) begin
            r = MAX32;
        end
        else if (a < SAT_MIN) begin
            r = MIN32;
        end
        else begin
            r = a[31:0];
        end
        return r;
    endfunction

    // Apply a sign to an unsigned quotient and clamp to 32 bits signed.
    function automatic logic signed [31:0] sat_quot(input logic [31:0] q, input logic ovf,
                                                    input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (ovf || (q[31] && (q[30:0] != '0))) begin
                r = MIN32;
            end
            else begin
                r = $signed(32'd0 - q);
            end
        end
        else begin
            if (ovf || q[31]) begin
                r = MAX32;
            end
            else begin
                r = $signed(q);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/mci_delay.sv
// Enabled shift line that keeps side data aligned with the arithmetic stages.
`default_nettype none

module mci_delay import mci_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    // Shift one place per advancing cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                pipe_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            pipe_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

`default_nettype wire

### rtl/mci_divider.sv
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
`default_nettype none

module mci_divider import mci_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [HI_W-1:0]  den,
    output logic [QBITS-1:0] quo,
    output logic             ovf
);

    logic [HI_W-1:0]  rem_reg [QBITS+1];
    logic [QBITS-1:0] sw_reg  [QBITS+1];
    logic             ovf_reg [QBITS+1];

    logic [HI_W:0]    trial [1:QBITS];
    logic [HI_W:0]    diff  [1:QBITS];
    logic             ge    [1:QBITS];
    logic [HI_W-1:0]  rem_next [1:QBITS];

    // Trial subtraction of each stage.
    always_comb
    begin
        for (int k = 1; k <= QBITS; k++)
        begin
            trial[k]    = {rem_reg[k-1], sw_reg[k-1][QBITS-1]};
            diff[k]     = trial[k] - {1'b0, den};
            ge[k]       = trial[k] >= {1'b0, den};
            rem_next[k] = ge[k] ? diff[k][HI_W-1:0] : trial[k][HI_W-1:0];
        end
    end

    // The shift word carries the unused numerator bits and collects quotient bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num[NUM_W-1:QBITS];
            sw_reg[0]  <= num[QBITS-1:0];
            ovf_reg[0] <= num[NUM_W-1:QBITS] >= den;
            for (int k = 1; k <= QBITS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                sw_reg[k]  <= {sw_reg[k-1][QBITS-2:0], ge[k]};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = sw_reg[QBITS];
    assign ovf = ovf_reg[QBITS];

endmodule

`default_nettype wire

### rtl/mci_rate.sv
// Rate unit F(x,n) = fx*(1-n) - gx*n with pipelined position scaling.
`default_nettype none

module mci_rate import mci_pkg::*;
#(
    parameter int CTX_W = 64,
    parameter int FRAC  = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  cfg_t               cfg,
    input  logic               in_vld,
    input  logic signed [31:0] xr,
    input  logic signed [31:0] nr,
    input  logic [CTX_W-1:0]   in_ctx,
    output logic               out_vld,
    output logic signed [31:0] rate,
    output logic [CTX_W-1:0]   out_ctx
);

    logic [61:0]        prod_f_reg;
    logic [61:0]        prod_g_reg;
    logic [QBITS-1:0]   fq;
    logic [QBITS-1:0]   gq;
    logic               f_ovf;
    logic               g_ovf;
    logic               in_range;
    logic               pos;
    logic               rng_d;
    logic               pos_d;
    logic signed [31:0] n_d;
    logic signed [31:0] fx_reg;
    logic signed [31:0] gx_reg;
    logic signed [31:0] omn_reg;
    logic signed [31:0] n_reg;
    logic signed [63:0] p1_reg;
    logic signed [63:0] p2_reg;
    logic signed [31:0] m1_reg;
    logic signed [31:0] m2_reg;
    logic signed [31:0] rate_reg;

    assign pos      = !xr[31];
    assign in_range = pos && (xr[30:0] <= cfg.reach);

    // Numerators f1*x and g1*x; only used for nonnegative positions.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_f_reg <= 62'(cfg.attach) * 62'(xr[30:0]);
            prod_g_reg <= 62'(cfg.detach) * 62'(xr[30:0]);
        end
    end

    mci_divider u_div_f
    (
        .clk (clk),
        .en  (en),
        .num ({1'b0, prod_f_reg}),
        .den (cfg.reach_div),
        .quo (fq),
        .ovf (f_ovf)
    );

    mci_divider u_div_g
    (
        .clk (clk),
        .en  (en),
        .num ({1'b0, prod_g_reg}),
        .den (cfg.reach_div),
        .quo (gq),
        .ovf (g_ovf)
    );

    // Range flags and n travel beside the dividers.
    mci_delay #(.WIDTH(34), .DEPTH(DIV_LAT + 1)) u_flag_dly
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     ({in_range, pos, nr}),
        .q     ({rng_d, pos_d, n_d})
    );

    // Caller context and valid bit travel through the whole unit.
    mci_delay #(.WIDTH(CTX_W + 1), .DEPTH(RATE_LAT)) u_ctx_dly
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     ({in_vld, in_ctx}),
        .q     ({out_vld, out_ctx})
    );

    // Select fx, gx and form 1-n, then the two products, shifts and difference.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_reg   <= rng_d ? sat_quot(fq, f_ovf, 1'b0) : '0;
            gx_reg   <= pos_d ? sat_quot(gq, g_ovf, 1'b0) : $signed({1'b0, cfg.neg_detach});
            omn_reg  <= sat64((64'sd1 <<< FRAC) - 64'(n_d));
            n_reg    <= n_d;
            p1_reg   <= 64'(fx_reg) * 64'(omn_reg);
            p2_reg   <= 64'(gx_reg) * 64'(n_reg);
            m1_reg   <= sat64(p1_reg >>> FRAC);
            m2_reg   <= sat64(p2_reg >>> FRAC);
            rate_reg <= sat64(64'(m1_reg) - 64'(m2_reg));
        end
    end

    assign rate = rate_reg;

endmodule

`default_nettype wire

### rtl/mci_corrector.sv
// One trapezoid corrector pass: new position, velocity, rate and bound fraction.
`default_nettype none

module mci_corrector import mci_pkg::*;
#(
    parameter int FRAC = 20
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  cfg_t cfg,
    input  st_t  st_in,
    output st_t  st_out
);

    localparam int CTX_W = $bits(st_t) + 1;

    logic signed [63:0] dt64;
    logic signed [63:0] p1_reg;
    st_t                st1_reg;
    st_t                st2_next;
    st_t                st2_reg;
    logic signed [32:0] dx;
    logic               dx_neg;
    logic [32:0]        dx_mag;
    logic [QBITS-1:0]   vq;
    logic               v_ovf;
    logic [QBITS-1:0]   vq_d;
    logic               v_ovf_d;
    logic               r_vld;
    logic signed [31:0] fn;
    logic [CTX_W-1:0]   r_ctx;
    logic               r_neg;
    st_t                r_st;
    logic signed [31:0] vn;
    st_t                st4_next;
    st_t                st4_reg;
    logic signed [63:0] p2_reg;
    st_t                out_next;
    st_t                out_reg;

    assign dt64 = $signed({33'b0, cfg.time_step});

    // Position half-step: (vc + v) * dt, then x + sum/2.
    always_comb
    begin
        st2_next    = st1_reg;
        st2_next.xc = sat64(64'(st1_reg.x) + (p1_reg >>> (FRAC + 1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg <= '0;
            st2_reg <= '0;
        end
        else if (en)
        begin
            st1_reg <= st_in;
            st2_reg <= st2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= (64'(st_in.vc) + 64'(cfg.velocity)) * dt64;
        end
    end

    // Velocity from the position change: |xn - x| * 2^F / dt.
    assign dx     = 33'(st2_reg.xc) - 33'(st2_reg.x);
    assign dx_neg = dx[32];
    assign dx_mag = dx_neg ? 33'(-dx) : 33'(dx);

    mci_divider u_div_v
    (
        .clk (clk),
        .en  (en),
        .num (NUM_W'(dx_mag[31:0]) << FRAC),
        .den (cfg.dt_div),
        .quo (vq),
        .ovf (v_ovf)
    );

    mci_delay #(.WIDTH(QBITS + 1), .DEPTH(RATE_LAT - DIV_LAT)) u_v_dly
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     ({v_ovf, vq}),
        .q     ({v_ovf_d, vq_d})
    );

    // Rate at the new position with the current bound-fraction estimate.
    mci_rate #(.CTX_W(CTX_W), .FRAC(FRAC)) u_rate
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg),
        .in_vld  (st2_reg.vld),
        .xr      (st2_reg.xc),
        .nr      (st2_reg.nc),
        .in_ctx  ({dx_neg, st2_reg}),
        .out_vld (r_vld),
        .rate    (fn),
        .out_ctx (r_ctx)
    );

    assign {r_neg, r_st} = r_ctx;
    assign vn = sat_quot(vq_d, v_ovf_d, r_neg);

    // Collect the pass results and the changes against the previous pass.
    always_comb
    begin
        st4_next     = r_st;
        st4_next.vld = r_vld;
        st4_next.vc  = vn;
        st4_next.fc  = fn;
        st4_next.dv  = sat64(64'(vn) - 64'(r_st.vc));
        st4_next.df  = sat64(64'(fn) - 64'(r_st.fc));
    end

    // Bound fraction update: n + (fn + f0)/2 * dt.
    always_comb
    begin
        out_next    = st4_reg;
        out_next.nc = sat64(64'(st4_reg.n) + (p2_reg >>> (FRAC + 1)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg <= (64'(fn) + 64'(r_st.f0)) * dt64;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st4_reg <= '0;
            out_reg <= '0;
        end
        else if (en)
        begin
            st4_reg <= st4_next;
            out_reg <= out_next;
        end
    end

    assign st_out = out_reg;

endmodule

`default_nettype wire

### rtl/muscle_crossbridge_integrator.sv
// Throughput: one item per cycle while the pipeline advances; each division
// is a pipelined unit that resolves one quotient bit per stage.
// The whole pipeline advances unless a result waits in the output register.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// default configuration; no clearing pass is needed.
`default_nettype none

module muscle_crossbridge_integrator import mci_pkg::*;
#(
    parameter int ITERATIONS    = 10,
    parameter int FRACTION_BITS = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   position,
    input  logic signed [31:0]   bound_fraction,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   new_position,
    output logic signed [31:0]   new_bound_fraction,
    output logic signed [31:0]   rate_value,
    output logic signed [31:0]   velocity_value,
    output logic signed [31:0]   rate_change,
    output logic signed [31:0]   velocity_change
);

    logic [30:0]        time_step_reg;
    logic signed [31:0] velocity_reg;
    logic [30:0]        attach_reg;
    logic [30:0]        detach_reg;
    logic [30:0]        neg_detach_reg;
    logic [30:0]        reach_reg;
    cfg_t               cfg_q;
    logic               en;
    logic               f0_vld;
    logic signed [31:0] f0_rate;
    logic [63:0]        f0_ctx;
    st_t                front1_next;
    st_t                front1_reg;
    st_t                front2_reg;
    st_t                front3_next;
    st_t                front3_reg;
    logic signed [63:0] front_p_reg;
    logic signed [31:0] front_m_reg;
    st_t                st_chain [ITERATIONS+1];
    st_t                out_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= 31'd1049;
            velocity_reg   <= 32'sd112618086;
            attach_reg     <= 31'd45403341;
            detach_reg     <= 31'd10485760;
            neg_detach_reg <= 31'd219152384;
            reach_reg      <= 31'd16357786;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TIME_STEP:  time_step_reg  <= cfg_data[30:0];
                REG_VELOCITY:   velocity_reg   <= $signed(cfg_data);
                REG_ATTACH:     attach_reg     <= cfg_data[30:0];
                REG_DETACH:     detach_reg     <= cfg_data[30:0];
                REG_NEG_DETACH: neg_detach_reg <= cfg_data[30:0];
                REG_REACH:      reach_reg      <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    // Datapath view of the configuration; a zero divisor counts as one LSB.
    always_comb
    begin
        cfg_q.time_step  = time_step_reg;
        cfg_q.dt_div     = (time_step_reg == '0) ? 31'd1 : time_step_reg;
        cfg_q.velocity   = velocity_reg;
        cfg_q.attach     = attach_reg;
        cfg_q.detach     = detach_reg;
        cfg_q.neg_detach = neg_detach_reg;
        cfg_q.reach      = reach_reg;
        cfg_q.reach_div  = (reach_reg == '0) ? 31'd1 : reach_reg;
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign en       = !out_reg.vld || !out_stall;
    assign in_stall = !en;

    // Initial rate f0 = F(x, n).
    mci_rate #(.CTX_W(64), .FRAC(FRACTION_BITS)) u_rate0
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg_q),
        .in_vld  (in_valid),
        .xr      (position),
        .nr      (bound_fraction),
        .in_ctx  ({position, bound_fraction}),
        .out_vld (f0_vld),
        .rate    (f0_rate),
        .out_ctx (f0_ctx)
    );

    // Predictor state: velocity v, rate f0, and n + f0*dt.
    always_comb
    begin
        front1_next     = '0;
        front1_next.vld = f0_vld;
        front1_next.x   = f0_ctx[63:32];
        front1_next.n   = f0_ctx[31:0];
        front1_next.f0  = f0_rate;
        front1_next.fc  = f0_rate;
        front1_next.vc  = cfg_q.velocity;
        front1_next.xc  = f0_ctx[63:32];
    end

    always_comb
    begin
        front3_next    = front2_reg;
        front3_next.nc = sat64(64'(front2_reg.n) + 64'(front_m_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_p_reg <= 64'(f0_rate) * $signed({33'b0, cfg_q.time_step});
            front_m_reg <= sat64(front_p_reg >>> FRACTION_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front1_reg <= '0;
            front2_reg <= '0;
            front3_reg <= '0;
        end
        else if (en)
        begin
            front1_reg <= front1_next;
            front2_reg <= front1_reg;
            front3_reg <= front3_next;
        end
    end

    assign st_chain[0] = front3_reg;

    // Corrector passes in series.
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_pass
        mci_corrector #(.FRAC(FRACTION_BITS)) u_pass
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .cfg    (cfg_q),
            .st_in  (st_chain[i]),
            .st_out (st_chain[i+1])
        );
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (en)
        begin
            out_reg <= st_chain[ITERATIONS];
        end
    end

    assign out_valid          = out_reg.vld;
    assign new_position       = out_reg.xc;
    assign new_bound_fraction = out_reg.nc;
    assign rate_value         = out_reg.fc;
    assign velocity_value     = out_reg.vc;
    assign rate_change        = out_reg.df;
    assign velocity_change    = out_reg.dv;

    // A waiting result freezes the last pass.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(st_chain[ITERATIONS]))
        else $error("pipeline moved while the output was stalled");

    // Input stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

    // Divisors are never zero.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_q.dt_div != '0) && (cfg_q.reach_div != '0))
        else $error("zero divisor reached the datapath");

endmodule

`default_nettype wire
